FILE: rtl/pwli_pkg.sv
// Shared types, constants and helper functions of the piecewise linear interpolator.
// Used by the channel interfaces and by the top level; depends on nothing else.

package pwli_pkg;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = 4;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // Width of the shared adder: wide enough for y0 plus or minus a clamped quotient.
  localparam int ALU_W   = 37;
  // Quotient bits produced by the divider; anything larger saturates the result.
  localparam int QUO_W   = 35;
  localparam int QCNT_W  = 6;
  localparam int PROD_W  = 2 * DATA_W;

  localparam logic [QUO_W-1:0] QUO_SAT = QUO_W'(64'd1 << (QUO_W - 1));

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSIDE = 2'd0;
  localparam logic [STAT_W-1:0] ST_BELOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABOVE  = 2'd2;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  function automatic logic [ALU_W-1:0] sext_alu(input logic [DATA_W-1:0] v);
    return {{(ALU_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // Magnitude of a signed difference of two 32-bit values.
  function automatic logic [DATA_W-1:0] mag_diff(input logic [DATA_W:0] d);
    logic [DATA_W:0] neg_d;
    neg_d = ~d + (DATA_W + 1)'(1);
    return d[DATA_W] ? neg_d[DATA_W-1:0] : d[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sat_alu(input logic [ALU_W-1:0] v);
    logic fits;
    fits = (&v[ALU_W-1:DATA_W-1]) || !(|v[ALU_W-1:DATA_W-1]);
    if (fits) begin
      return v[DATA_W-1:0];
    end else if (v[ALU_W-1]) begin
      return VAL_MIN;
    end else begin
      return VAL_MAX;
    end
  endfunction

endpackage

FILE: rtl/pwli_in_if.sv
// Input channel of the piecewise linear interpolator: breakpoint writes and queries.
// Depends on pwli_pkg for field widths.

interface pwli_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic        [pwli_pkg::IDX_W-1:0]   point_index;
  logic signed [pwli_pkg::DATA_W-1:0]  point_x;
  logic signed [pwli_pkg::DATA_W-1:0]  point_y;
  logic signed [pwli_pkg::DATA_W-1:0]  query_x;

  modport source(output valid, action, point_index, point_x, point_y, query_x,
                 input ready);
  modport sink(input valid, action, point_index, point_x, point_y, query_x,
               output ready);
endinterface

FILE: rtl/pwli_out_if.sv
// Result channel of the piecewise linear interpolator: value and range status.
// Depends on pwli_pkg for field widths.

interface pwli_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pwli_pkg::DATA_W-1:0]  interp_value;
  logic        [pwli_pkg::STAT_W-1:0]  range_status;

  modport source(output valid, interp_value, range_status, input ready);
  modport sink(input valid, interp_value, range_status, output ready);
endinterface

FILE: rtl/piecewise_linear_interp.sv
// Piecewise linear interpolator over a breakpoint table, built around one shared adder.
// Depends on pwli_pkg, pwli_in_if and pwli_out_if.
//
// Usage: items arrive on in_if (valid/ready). An item with action write stores
// point_x and point_y in slot point_index (slots at or above MAX_POINTS are
// ignored); it gives no result and the block is ready again in the next cycle.
// An item with action query produces one transfer on out_if carrying the
// interpolated value (saturated to 32 bits) and the range status.
// cfg_wr_en/cfg_wr_data set the number of breakpoints in use; write it only
// while the block is idle. Table entries must be written before they are used.
// A query below the table is answered from the first comparison and one above
// it from the second. Inside the table the search reads one table entry per
// cycle until it finds the segment; the differences and their product follow,
// and the divider retires one quotient bit per cycle on the shared adder. The
// divider is skipped when a difference is zero or when the quotient saturates.
// One item is processed at a time; in_if.ready is low while a query is worked on.
// A finished result waits in the output register, so a new item is accepted
// while the receiver stalls; a second result then waits until the first transfer.
// Reset (rst_n, synchronous) empties the output and sets the point count to 2;
// the table contents are not cleared.

module piecewise_linear_interp #(
  parameter int MAX_POINTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pwli_in_if.sink                       in_if,
  pwli_out_if.source                    out_if,
  input  logic                          cfg_wr_en,
  input  logic [pwli_pkg::COUNT_W-1:0]  cfg_wr_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DW = pwli_pkg::DATA_W;
  localparam int QW = pwli_pkg::QUO_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LO, S_HI, S_SRCH, S_DX, S_DY, S_DEN,
    S_MUL, S_CHK, S_DIV, S_ADD, S_PUT
  } state_t;

  logic [DW-1:0] x_mem [MAX_POINTS];
  logic [DW-1:0] y_mem [MAX_POINTS];

  state_t                          state_r, state_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [DW-1:0]                   out_value_r, out_value_nxt;
  logic [pwli_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [pwli_pkg::COUNT_W-1:0]    count_r;
  logic [AW-1:0]                   ra_r, ra_nxt;

  logic [DW-1:0]                   rdx_r, rdy_r;
  logic [DW-1:0]                   qx_r, qx_nxt;
  logic [AW-1:0]                   nm1_r, nm1_nxt;
  logic [DW-1:0]                   p_x_r, p_x_nxt, p_y_r, p_y_nxt;
  logic [DW-1:0]                   x1_r, x1_nxt, y1_r, y1_nxt;
  logic [DW-1:0]                   dx_mag_r, dx_mag_nxt, dy_mag_r, dy_mag_nxt;
  logic [DW-1:0]                   den_mag_r, den_mag_nxt;
  logic                            dx_neg_r, dx_neg_nxt, dy_neg_r, dy_neg_nxt;
  logic                            den_neg_r, den_neg_nxt, neg_r, neg_nxt;
  logic [pwli_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic [DW-1:0]                   rem_r, rem_nxt;
  logic [QW-1:0]                   dvd_r, dvd_nxt;
  logic [pwli_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DW-1:0]                   res_value_r, res_value_nxt;
  logic [pwli_pkg::STAT_W-1:0]     res_status_r, res_status_nxt;

  logic [pwli_pkg::ALU_W-1:0]      alu_a, alu_b, alu_sum;
  logic                            alu_sub, alu_neg;

  logic                            wr_en, slot_ok;
  logic [AW-1:0]                   wr_addr, nm1_calc;

  assign alu_sum = alu_a + (alu_b ^ {pwli_pkg::ALU_W{alu_sub}})
                   + pwli_pkg::ALU_W'(alu_sub);
  assign alu_neg = alu_sum[pwli_pkg::ALU_W-1];

  assign slot_ok = 32'(in_if.point_index) < MAX_POINTS;
  assign wr_addr = AW'(in_if.point_index);

  always_comb begin
    if (count_r < pwli_pkg::COUNT_W'(2)) begin
      nm1_calc = AW'(1);
    end else if (32'(count_r) > MAX_POINTS) begin
      nm1_calc = AW'(MAX_POINTS - 1);
    end else begin
      nm1_calc = AW'(count_r - pwli_pkg::COUNT_W'(1));
    end
  end

  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.interp_value = out_value_r;
  assign out_if.range_status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ra_nxt         = ra_r;
    qx_nxt         = qx_r;
    nm1_nxt        = nm1_r;
    p_x_nxt        = p_x_r;
    p_y_nxt        = p_y_r;
    x1_nxt         = x1_r;
    y1_nxt         = y1_r;
    dx_mag_nxt     = dx_mag_r;
    dy_mag_nxt     = dy_mag_r;
    den_mag_nxt    = den_mag_r;
    dx_neg_nxt     = dx_neg_r;
    dy_neg_nxt     = dy_neg_r;
    den_neg_nxt    = den_neg_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    cnt_nxt        = cnt_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    alu_a          = '0;
    alu_b          = '0;
    alu_sub        = 1'b1;
    wr_en          = 1'b0;

    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        ra_nxt = '0;
        if (in_if.valid) begin
          if (in_if.action == pwli_pkg::ACT_WRITE) begin
            wr_en = slot_ok;
          end else begin
            qx_nxt    = in_if.query_x;
            nm1_nxt   = nm1_calc;
            state_nxt = S_LO;
          end
        end
      end
      S_LO: begin
        alu_a   = pwli_pkg::sext_alu(qx_r);
        alu_b   = pwli_pkg::sext_alu(rdx_r);
        p_x_nxt = rdx_r;
        p_y_nxt = rdy_r;
        if (alu_neg) begin
          res_value_nxt  = rdy_r;
          res_status_nxt = pwli_pkg::ST_BELOW;
          state_nxt      = S_PUT;
        end else begin
          ra_nxt    = nm1_r;
          state_nxt = S_HI;
        end
      end
      S_HI: begin
        alu_a = pwli_pkg::sext_alu(rdx_r);
        alu_b = pwli_pkg::sext_alu(qx_r);
        if (alu_neg) begin
          res_value_nxt  = rdy_r;
          res_status_nxt = pwli_pkg::ST_ABOVE;
          state_nxt      = S_PUT;
        end else begin
          ra_nxt    = AW'(1);
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        alu_a = pwli_pkg::sext_alu(rdx_r);
        alu_b = pwli_pkg::sext_alu(qx_r);
        if (alu_neg && (ra_r < nm1_r)) begin
          p_x_nxt = rdx_r;
          p_y_nxt = rdy_r;
          ra_nxt  = ra_r + AW'(1);
        end else begin
          x1_nxt    = rdx_r;
          y1_nxt    = rdy_r;
          state_nxt = S_DX;
        end
      end
      S_DX: begin
        alu_a      = pwli_pkg::sext_alu(qx_r);
        alu_b      = pwli_pkg::sext_alu(p_x_r);
        dx_mag_nxt = pwli_pkg::mag_diff(alu_sum[DW:0]);
        dx_neg_nxt = alu_sum[DW];
        state_nxt  = S_DY;
      end
      S_DY: begin
        alu_a      = pwli_pkg::sext_alu(y1_r);
        alu_b      = pwli_pkg::sext_alu(p_y_r);
        dy_mag_nxt = pwli_pkg::mag_diff(alu_sum[DW:0]);
        dy_neg_nxt = alu_sum[DW];
        state_nxt  = S_DEN;
      end
      S_DEN: begin
        alu_a       = pwli_pkg::sext_alu(x1_r);
        alu_b       = pwli_pkg::sext_alu(p_x_r);
        den_mag_nxt = pwli_pkg::mag_diff(alu_sum[DW:0]);
        den_neg_nxt = alu_sum[DW];
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        neg_nxt  = (dx_neg_r ^ dy_neg_r) ^ den_neg_r;
        prod_nxt = pwli_pkg::PROD_W'(dx_mag_r) * pwli_pkg::PROD_W'(dy_mag_r);
        if ((den_mag_r == '0) || (dx_mag_r == '0) || (dy_mag_r == '0)) begin
          res_value_nxt  = p_y_r;
          res_status_nxt = pwli_pkg::ST_INSIDE;
          state_nxt      = S_PUT;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        alu_a = pwli_pkg::ALU_W'(prod_r[pwli_pkg::PROD_W-1:QW]);
        alu_b = pwli_pkg::ALU_W'(den_mag_r);
        if (!alu_neg) begin
          dvd_nxt   = pwli_pkg::QUO_SAT;
          state_nxt = S_ADD;
        end else begin
          rem_nxt   = DW'(prod_r[pwli_pkg::PROD_W-1:QW]);
          dvd_nxt   = prod_r[QW-1:0];
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        alu_a = pwli_pkg::ALU_W'({rem_r, dvd_r[QW-1]});
        alu_b = pwli_pkg::ALU_W'(den_mag_r);
        if (!alu_neg) begin
          rem_nxt = alu_sum[DW-1:0];
        end else begin
          rem_nxt = {rem_r[DW-2:0], dvd_r[QW-1]};
        end
        dvd_nxt = {dvd_r[QW-2:0], !alu_neg};
        cnt_nxt = cnt_r + pwli_pkg::QCNT_W'(1);
        if (cnt_r == pwli_pkg::QCNT_W'(QW - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        alu_a          = pwli_pkg::sext_alu(p_y_r);
        alu_b          = pwli_pkg::ALU_W'(dvd_r);
        alu_sub        = neg_r;
        res_value_nxt  = pwli_pkg::sat_alu(alu_sum);
        res_status_nxt = pwli_pkg::ST_INSIDE;
        state_nxt      = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= pwli_pkg::COUNT_W'(2);
      ra_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ra_r        <= ra_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    qx_r         <= qx_nxt;
    nm1_r        <= nm1_nxt;
    p_x_r        <= p_x_nxt;
    p_y_r        <= p_y_nxt;
    x1_r         <= x1_nxt;
    y1_r         <= y1_nxt;
    dx_mag_r     <= dx_mag_nxt;
    dy_mag_r     <= dy_mag_nxt;
    den_mag_r    <= den_mag_nxt;
    dx_neg_r     <= dx_neg_nxt;
    dy_neg_r     <= dy_neg_nxt;
    den_neg_r    <= den_neg_nxt;
    neg_r        <= neg_nxt;
    prod_r       <= prod_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    cnt_r        <= cnt_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= in_if.point_x;
      y_mem[wr_addr] <= in_if.point_y;
    end
    rdx_r <= x_mem[ra_nxt];
    rdy_r <= y_mem[ra_nxt];
  end

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && (in_if.action == pwli_pkg::ACT_WRITE))
      |=> (state_r == S_IDLE))
    else $error("a breakpoint write left the idle state");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && (in_if.action == pwli_pkg::ACT_QUERY))
      |=> !in_if.ready)
    else $error("block still ready after a query transfer");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < den_mag_r))
    else $error("divider remainder not below the divisor");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> ((ra_r <= nm1_r) && (ra_r != '0)))
    else $error("segment search outside the active table");

  a_put_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PUT) && (!out_valid_r || out_if.ready))
      |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finished result was not placed in the output register");

endmodule
